// ===== rtl/core/tcd_pkg.sv =====
`timescale 1ns / 1ps

package tcd_pkg;

    localparam int ROWS_DEF = 30;
    localparam int COLS_DEF = 80;

    localparam logic [7:0] SPACE_CHAR = 8'd32;

    // command opcodes
    localparam logic [7:0] OP_SET  = 8'd1;
    localparam logic [7:0] OP_ADD  = 8'd2;
    localparam logic [7:0] OP_LINE = 8'd3;
    localparam logic [7:0] OP_TEXT = 8'd4;

    // command parser phase
    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_SET      = 3'd1,
        PH_ADD      = 3'd2,
        PH_LINE     = 3'd3,
        PH_TEXT_HDR = 3'd4,
        PH_TEXT     = 3'd5
    } phase_t;

    // engine control state
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_RUN,
        ST_LINE,
        ST_READ
    } eng_state_t;

endpackage

// ===== rtl/core/text_canvas_draw_command_engine.sv =====
`timescale 1ns / 1ps

// Channel | Direction | Handshake          | Payload
// --------+-----------+--------------------+---------------------------------------
// in      | input     | in_valid/in_ready   | kind, stream_byte, read_row, read_col
// out     | output    | out_valid/out_ready | cell_char
//
// Flow: each stream byte is taken in its own transfer, text bytes included.
//   The final length byte of a line command holds off input until all len cells
//   are painted, one cell write per cycle through the single canvas write port.
//   A read goes through the RAM read, then the load of the output register.
// Reset: after rst_n releases, the canvas is swept to spaces, one cell per
//   cycle over all ROWS*COLS (2400 at 30x80) cells; no input is taken meanwhile.
// Stalls: stream bytes keep flowing while a result waits on out_ready; a second
//   read waits until the output register frees up.
module text_canvas_draw_command_engine #(
    parameter int ROWS = tcd_pkg::ROWS_DEF,
    parameter int COLS = tcd_pkg::COLS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,

    input  logic       in_valid,
    output logic       in_ready,
    input  logic       kind,
    input  logic [7:0] stream_byte,
    input  logic [4:0] read_row,
    input  logic [6:0] read_col,

    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] cell_char
);

    localparam int CELLS = ROWS * COLS;
    localparam int CAW   = (CELLS > 1) ? $clog2(CELLS) : 1;

    // control state
    tcd_pkg::eng_state_t state_reg, state_next;
    tcd_pkg::phase_t     phase_reg, phase_next;
    logic [2:0]          opcnt_reg, opcnt_next;
    logic [CAW-1:0]      clear_cnt_reg, clear_cnt_next;
    logic                out_valid_reg, out_valid_next;
    logic                rd_oob_reg, rd_oob_next;

    // cursor and command operands
    logic [15:0] cursor_col_reg, cursor_col_next;
    logic [15:0] cursor_row_reg, cursor_row_next;
    logic [15:0] step_col_reg, step_col_next;
    logic [15:0] step_row_reg, step_row_next;
    logic [15:0] run_len_reg, run_len_next;
    logic [7:0]  fill_char_reg, fill_char_next;
    logic [7:0]  low_hold_reg, low_hold_next;

    // result payload
    logic [7:0]  cell_char_reg, cell_char_next;

    logic        byte_take;
    logic        read_take;
    logic        clearing;
    logic        painting;
    logic        out_free;
    logic        rd_load;
    logic        line_start;
    logic        text_wr;
    logic [15:0] word;

    logic        use_read;
    logic [7:0]  addr_row;
    logic [7:0]  addr_col;
    logic [15:0] row_base;
    logic [CAW-1:0] cell_addr;
    logic        cursor_in;
    logic        read_in;

    logic           ram_we;
    logic [CAW-1:0] ram_waddr;
    logic [7:0]     ram_wdata;
    logic [7:0]     ram_rdata;

    assign byte_take = in_valid && in_ready && !kind;
    assign read_take = in_valid && in_ready && kind;
    assign out_free  = !out_valid_reg || out_ready;
    assign word      = {stream_byte, low_hold_reg};

    // one address path, shared between the read lookup and the cursor write
    assign use_read  = in_ready && kind;
    assign addr_row  = use_read ? 8'(read_row) : cursor_row_reg[7:0];
    assign addr_col  = use_read ? 8'(read_col) : cursor_col_reg[7:0];
    assign row_base  = 16'(addr_row) * 16'(COLS);
    assign cell_addr = CAW'(row_base + 16'(addr_col));

    assign cursor_in = !cursor_row_reg[15] && (cursor_row_reg < 16'(ROWS))
                    && !cursor_col_reg[15] && (cursor_col_reg < 16'(COLS));
    assign read_in   = (9'(read_row) < 9'(ROWS)) && (9'(read_col) < 9'(COLS));

    // FSM: next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tcd_pkg::ST_CLEAR:
            begin
                if (clear_cnt_reg == CAW'(CELLS - 1))
                begin
                    state_next = tcd_pkg::ST_RUN;
                end
            end
            tcd_pkg::ST_RUN:
            begin
                if (read_take)
                begin
                    state_next = tcd_pkg::ST_READ;
                end
                else if (line_start)
                begin
                    state_next = tcd_pkg::ST_LINE;
                end
            end
            tcd_pkg::ST_LINE:
            begin
                if (run_len_reg == 16'd1)
                begin
                    state_next = tcd_pkg::ST_RUN;
                end
            end
            tcd_pkg::ST_READ:
            begin
                if (out_free)
                begin
                    state_next = tcd_pkg::ST_RUN;
                end
            end
            default:
            begin
                state_next = tcd_pkg::ST_CLEAR;
            end
        endcase
    end

    // FSM: outputs
    always_comb
    begin
        in_ready = 1'b0;
        clearing = 1'b0;
        painting = 1'b0;
        rd_load  = 1'b0;
        unique case (state_reg)
            tcd_pkg::ST_CLEAR: clearing = 1'b1;
            tcd_pkg::ST_RUN:   in_ready = 1'b1;
            tcd_pkg::ST_LINE:  painting = 1'b1;
            tcd_pkg::ST_READ:  rd_load  = out_free;
            default:           clearing = 1'b0;
        endcase
    end

    // command parser and cursor datapath
    always_comb
    begin
        phase_next      = phase_reg;
        opcnt_next      = opcnt_reg;
        cursor_col_next = cursor_col_reg;
        cursor_row_next = cursor_row_reg;
        step_col_next   = step_col_reg;
        step_row_next   = step_row_reg;
        run_len_next    = run_len_reg;
        fill_char_next  = fill_char_reg;
        low_hold_next   = low_hold_reg;
        line_start      = 1'b0;
        text_wr         = 1'b0;

        if (byte_take)
        begin
            unique case (phase_reg)
                tcd_pkg::PH_IDLE:
                begin
                    opcnt_next = 3'd0;
                    unique case (stream_byte)
                        tcd_pkg::OP_SET:  phase_next = tcd_pkg::PH_SET;
                        tcd_pkg::OP_ADD:  phase_next = tcd_pkg::PH_ADD;
                        tcd_pkg::OP_LINE: phase_next = tcd_pkg::PH_LINE;
                        tcd_pkg::OP_TEXT: phase_next = tcd_pkg::PH_TEXT_HDR;
                        default:          phase_next = tcd_pkg::PH_IDLE;
                    endcase
                end
                tcd_pkg::PH_SET, tcd_pkg::PH_ADD:
                begin
                    opcnt_next = opcnt_reg + 3'd1;
                    if (!opcnt_reg[0])
                    begin
                        low_hold_next = stream_byte;
                    end
                    else if (opcnt_reg == 3'd1)
                    begin
                        if (phase_reg == tcd_pkg::PH_SET)
                        begin
                            cursor_col_next = word;
                        end
                        else
                        begin
                            step_col_next = word;
                        end
                    end
                    else
                    begin
                        if (phase_reg == tcd_pkg::PH_SET)
                        begin
                            cursor_row_next = word;
                        end
                        else
                        begin
                            step_row_next   = word;
                            cursor_col_next = cursor_col_reg + step_col_reg;
                            cursor_row_next = cursor_row_reg + word;
                        end
                        phase_next = tcd_pkg::PH_IDLE;
                        opcnt_next = 3'd0;
                    end
                end
                tcd_pkg::PH_LINE:
                begin
                    opcnt_next = opcnt_reg + 3'd1;
                    if (opcnt_reg == 3'd0)
                    begin
                        fill_char_next = stream_byte;
                    end
                    else if (opcnt_reg[0])
                    begin
                        low_hold_next = stream_byte;
                    end
                    else if (opcnt_reg == 3'd2)
                    begin
                        step_col_next = word;
                    end
                    else if (opcnt_reg == 3'd4)
                    begin
                        step_row_next = word;
                    end
                    else
                    begin
                        // len: positive starts the paint loop
                        run_len_next = word;
                        line_start   = !word[15] && (word != 16'd0);
                        phase_next   = tcd_pkg::PH_IDLE;
                        opcnt_next   = 3'd0;
                    end
                end
                tcd_pkg::PH_TEXT_HDR:
                begin
                    opcnt_next = opcnt_reg + 3'd1;
                    if (!opcnt_reg[0])
                    begin
                        low_hold_next = stream_byte;
                    end
                    else if (opcnt_reg == 3'd1)
                    begin
                        step_col_next = word;
                    end
                    else if (opcnt_reg == 3'd3)
                    begin
                        step_row_next = word;
                    end
                    else
                    begin
                        opcnt_next = 3'd0;
                        if (!word[15] && (word != 16'd0))
                        begin
                            run_len_next = word;
                            phase_next   = tcd_pkg::PH_TEXT;
                        end
                        else
                        begin
                            run_len_next = 16'd0;
                            phase_next   = tcd_pkg::PH_IDLE;
                        end
                    end
                end
                tcd_pkg::PH_TEXT:
                begin
                    text_wr         = 1'b1;
                    cursor_col_next = cursor_col_reg + step_col_reg;
                    cursor_row_next = cursor_row_reg + step_row_reg;
                    run_len_next    = run_len_reg - 16'd1;
                    if (run_len_reg == 16'd1)
                    begin
                        phase_next = tcd_pkg::PH_IDLE;
                    end
                end
                default:
                begin
                    phase_next = tcd_pkg::PH_IDLE;
                    opcnt_next = 3'd0;
                end
            endcase
        end

        if (painting)
        begin
            cursor_col_next = cursor_col_reg + step_col_reg;
            cursor_row_next = cursor_row_reg + step_row_reg;
            run_len_next    = run_len_reg - 16'd1;
        end
    end

    // clear sweep, read bookkeeping, output register
    always_comb
    begin
        clear_cnt_next = clearing ? (clear_cnt_reg + CAW'(1)) : clear_cnt_reg;
        rd_oob_next    = read_take ? !read_in : rd_oob_reg;
        out_valid_next = (out_valid_reg && !out_ready) || rd_load;
        cell_char_next = cell_char_reg;
        if (rd_load)
        begin
            cell_char_next = rd_oob_reg ? tcd_pkg::SPACE_CHAR : ram_rdata;
        end
    end

    // canvas write port: sweep, line paint or text byte; off-canvas writes dropped
    assign ram_we    = clearing || ((text_wr || painting) && cursor_in);
    assign ram_waddr = clearing ? clear_cnt_reg : cell_addr;
    assign ram_wdata = clearing ? tcd_pkg::SPACE_CHAR
                     : (painting ? fill_char_reg : stream_byte);

    tcd_ram #(
        .WIDTH (8),
        .DEPTH (CELLS)
    ) u_canvas (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (read_take),
        .raddr (cell_addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tcd_pkg::ST_CLEAR;
            phase_reg      <= tcd_pkg::PH_IDLE;
            opcnt_reg      <= 3'd0;
            clear_cnt_reg  <= '0;
            out_valid_reg  <= 1'b0;
            rd_oob_reg     <= 1'b0;
            cursor_col_reg <= 16'd0;
            cursor_row_reg <= 16'd0;
            step_col_reg   <= 16'd0;
            step_row_reg   <= 16'd0;
            run_len_reg    <= 16'd0;
            fill_char_reg  <= 8'd0;
            low_hold_reg   <= 8'd0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            opcnt_reg      <= opcnt_next;
            clear_cnt_reg  <= clear_cnt_next;
            out_valid_reg  <= out_valid_next;
            rd_oob_reg     <= rd_oob_next;
            cursor_col_reg <= cursor_col_next;
            cursor_row_reg <= cursor_row_next;
            step_col_reg   <= step_col_next;
            step_row_reg   <= step_row_next;
            run_len_reg    <= run_len_next;
            fill_char_reg  <= fill_char_next;
            low_hold_reg   <= low_hold_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cell_char_reg <= cell_char_next;
    end

    assign out_valid = out_valid_reg;
    assign cell_char = cell_char_reg;

`ifndef NO_ASSERTIONS
    // an accepted read always waits for RAM data in the read state
    a_read_seq: assert property (@(posedge clk) disable iff (!rst_n)
        read_take |=> state_reg == tcd_pkg::ST_READ)
        else $error("read transfer not followed by read state");

    // line paint only runs with a positive remaining length
    a_line_len: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == tcd_pkg::ST_LINE |-> (run_len_reg != 16'd0) && !run_len_reg[15])
        else $error("line paint with non-positive length");

    // a result appears only after a read lookup completed
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == tcd_pkg::ST_READ))
        else $error("result without a read lookup");

    // no canvas write while read data sits in the RAM output
    a_no_wr_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == tcd_pkg::ST_READ |-> !ram_we)
        else $error("canvas write during pending read");

    // text phase always has bytes left to take
    a_text_len: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == tcd_pkg::PH_TEXT |-> run_len_reg != 16'd0)
        else $error("text phase with zero length");
`endif

endmodule

// ===== rtl/core/tcd_ram.sv =====
`timescale 1ns / 1ps

// Simple dual-port RAM, one write and one registered read port.
module tcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2400
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
